>>> hdl/sti_pkg.sv
// sti_pkg: shared types and constants for the sorted table core
// no dependencies
package sti_pkg;

   // default table depth
   localparam int unsigned CAPACITY_DEF = 16;

   // request operation codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   // response status codes
   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_RESP = 1'b1
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic exec;
   } ctl_type;

endpackage

>>> hdl/sti_if.sv
// sti_if: request and response channel interfaces for the sorted table core
// no dependencies
interface sti_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [31:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sti_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [4:0]         entry_count;
   logic signed [31:0] smallest;
   logic               is_empty;

   modport source (output valid, output status, output entry_count, output smallest,
                   output is_empty, input ready);
   modport sink   (input valid, input status, input entry_count, input smallest,
                   input is_empty, output ready);
endinterface

>>> hdl/sti_ctrl.sv
// sti_ctrl: request/response handshake controller
// depends on sti_pkg
module sti_ctrl
   import sti_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output ctl_type ctl
);

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_RESP;
         end
         S_RESP: begin
            if (accept) state_in = S_RESP;
            else if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
      ctl.exec = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

>>> hdl/sti_dpath.sv
// sti_dpath: row of compare cells holding the sorted entries, count and status
// depends on sti_pkg
module sti_dpath
   import sti_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEF,
   localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   input  logic               cmd,
   input  logic signed [31:0] value,
   output status_type         status,
   output logic [CW-1:0]      count,
   output logic [4:0]         entry_count,
   output logic signed [31:0] smallest,
   output logic               is_empty
);

   logic signed [31:0] cells_ff [CAPACITY];
   logic signed [31:0] cells_in [CAPACITY];
   logic [CW-1:0]      count_ff, count_in;
   status_type         status_ff, status_in;

   logic [CAPACITY-1:0] valid, gtv, eqv, gev, at_end;
   logic                full, found;
   logic [31:0]         count_ext;

   // per-cell compares against the request value
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
      assign valid[i]  = CW'(i) < count_ff;
      assign at_end[i] = CW'(i) == count_ff;
      assign gtv[i]    = valid[i] && (cells_ff[i] > value);
      assign eqv[i]    = valid[i] && (cells_ff[i] == value);
      assign gev[i]    = valid[i] && (cells_ff[i] >= value);
   end

   assign full  = count_ff == CW'(CAPACITY);
   assign found = |eqv;

   // each cell picks hold, shift or the new value from its neighbors' compares
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic ins_shift, del_shift;
      if (i == 0) begin : g_first
         assign ins_shift = 1'b0;
      end else begin : g_rest
         assign ins_shift = gtv[i-1];
      end
      always_comb begin
         cells_in[i] = cells_ff[i];
         if (cmd == CMD_INSERT) begin
            if (!full) begin
               if (ins_shift) cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
               else if (gtv[i] || at_end[i]) cells_in[i] = value;
            end
         end else if (del_shift) begin
            cells_in[i] = cells_ff[(i + 1 < CAPACITY) ? i + 1 : i];
         end
      end
      // sorted order puts the first equal entry at the first cell not below value
      assign del_shift = found && gev[i] && (i + 1 < CAPACITY);
   end

   always_comb begin
      count_in  = count_ff;
      status_in = ST_DONE;
      if (cmd == CMD_INSERT) begin
         if (full) status_in = ST_FULL;
         else count_in = count_ff + CW'(1);
      end else begin
         if (found) count_in = count_ff - CW'(1);
         else status_in = ST_NOT_FOUND;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         for (int i = 0; i < CAPACITY; i++) cells_ff[i] <= cells_in[i];
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (ctl.exec) count_ff <= count_in;
   end

   assign count_ext   = 32'(count_ff);
   assign status      = status_ff;
   assign count       = count_ff;
   assign entry_count = count_ext[4:0];
   assign is_empty    = count_ff == '0;
   assign smallest    = is_empty ? 32'sd0 : cells_ff[0];

endmodule

>>> hdl/sorted_table_insert_delete_core.sv
// sorted table core: request to response in the next cycle
// throughput one request per cycle while responses are taken; a pending response
// stalls new requests until it is accepted (single response register)
// reset clears the entry count and controller state; entry storage is not cleared
// and is only read below the count
module sorted_table_insert_delete_core
   import sti_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sti_req_if.sink   req_bus,
   sti_rsp_if.source rsp_bus
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   ctl_type       ctl;
   status_type    status;
   logic [CW-1:0] count;

   // handshake controller: one response register, next request taken as it drains
   sti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctl       (ctl)
   );

   // compare-per-cell table: insert shifts up, delete shifts down
   sti_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .cmd         (req_bus.cmd),
      .value       (req_bus.value),
      .status      (status),
      .count       (count),
      .entry_count (rsp_bus.entry_count),
      .smallest    (rsp_bus.smallest),
      .is_empty    (rsp_bus.is_empty)
   );

   assign rsp_bus.status = status;

   // an accepted request always produces a response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> rsp_bus.valid)
      else $error("no response after accepted request");

   // full status only when the table really is full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && status == ST_FULL) |-> (count == CW'(CAPACITY)))
      else $error("full status with room left");

   // count never exceeds capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // empty table reports zero as its smallest value
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.is_empty) |-> (rsp_bus.smallest == 32'sd0))
      else $error("empty table with nonzero smallest");

endmodule
